FILE: rtl/core/seg_dist_pkg.sv
// Shared widths, latencies, case codes and bundle types for the segment
// distance pipeline. Used by every module under rtl/core.
`default_nettype none

package seg_dist_pkg;

  // Coordinates and reduced vectors
  localparam int COORD_FRAC_BITS = 16;
  localparam int RED_SHIFT       = COORD_FRAC_BITS / 2;
  localparam int CW              = 32;               // endpoint coordinate
  localparam int DW              = CW + 1;           // endpoint difference
  localparam int RW              = DW - RED_SHIFT + 1; // reduced difference
  localparam int DOTW            = 2 * RW + 2;       // dot products a, b, c, e, f
  localparam int HALFW           = DOTW / 2;         // split for wide products
  localparam int BIGW            = 2 * DOTW + 2;     // a*e - b*b, b*f - c*e

  // Closest point parameters
  localparam int PF              = 16;
  localparam logic [PF:0] PAR_ONE = {1'b1, {PF{1'b0}}};
  localparam int NW              = DOTW + PF + 2;    // n = b*s + f*2^16

  // Closest points and distance
  localparam int CPW             = CW + 2;           // closest point coordinate
  localparam int MAGW            = CPW;              // |c1 - c2|
  localparam int MH              = MAGW / 2;
  localparam int SQW             = 2 * MAGW + 2;     // sum of squares
  localparam int RTW             = SQW / 2;          // square root
  localparam int DIST_W          = 33;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Pipeline latencies
  localparam int FRONT_LAT = 9;
  localparam int DIV_LAT   = PF + 2;
  localparam int SQRT_LAT  = RTW + 2;

  typedef enum logic [1:0] {
    CASE_GENERAL    = 2'd0,
    CASE_FIRST_DEG  = 2'd1,
    CASE_SECOND_DEG = 2'd2,
    CASE_BOTH_DEG   = 2'd3
  } case_e;

  // Endpoint data that the request keeps until the closest points
  typedef struct packed {
    logic [2:0][CW-1:0] p1;
    logic [2:0][CW-1:0] p2;
    logic [2:0][DW-1:0] d1;
    logic [2:0][DW-1:0] d2;
    logic [2:0][DW-1:0] rv;
  } geo_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] e;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] f;
    case_e                  cs;
  } dot_t;

  // Front end result: dot products and the first quotient operands
  typedef struct packed {
    dot_t                   dot;
    logic signed [BIGW-1:0] num;
    logic signed [BIGW-1:0] den;
  } fr_t;

endpackage

`default_nettype wire

FILE: rtl/core/seg_dist_front.sv
// Front end: reduced vectors, dot products, degenerate test and the
// wide products for the first quotient. Depends on seg_dist_pkg.
`default_nettype none

module seg_dist_front
  import seg_dist_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] thr_i,
  input  geo_t        geo_i,
  output fr_t         fr_o
);

  localparam int PR_AE = 0;
  localparam int PR_BB = 1;
  localparam int PR_BF = 2;
  localparam int PR_CE = 3;
  localparam int NPR   = 4;

  function automatic logic signed [RW-1:0] reduce(input logic [DW-1:0] v);
    logic signed [DW:0] t;
    t = {v[DW-1], v} + ((DW+1)'(1) << (RED_SHIFT - 1));
    t = t >>> RED_SHIFT;
    return t[RW-1:0];
  endfunction

  function automatic logic [DOTW-1:0] mag(input logic signed [DOTW-1:0] v);
    return v[DOTW-1] ? DOTW'(-v) : DOTW'(v);
  endfunction

  // F1: reduce differences, round half up
  logic signed [RW-1:0] rd1_q [3];
  logic signed [RW-1:0] rd2_q [3];
  logic signed [RW-1:0] rr_q  [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rd1_q[i] <= reduce(geo_i.d1[i]);
        rd2_q[i] <= reduce(geo_i.d2[i]);
        rr_q[i]  <= reduce(geo_i.rv[i]);
      end
    end
  end

  // F2: component products
  logic signed [2*RW-1:0] paa_q [3];
  logic signed [2*RW-1:0] pee_q [3];
  logic signed [2*RW-1:0] pbb_q [3];
  logic signed [2*RW-1:0] pcc_q [3];
  logic signed [2*RW-1:0] pff_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        paa_q[i] <= rd1_q[i] * rd1_q[i];
        pee_q[i] <= rd2_q[i] * rd2_q[i];
        pbb_q[i] <= rd1_q[i] * rd2_q[i];
        pcc_q[i] <= rd1_q[i] * rr_q[i];
        pff_q[i] <= rd2_q[i] * rr_q[i];
      end
    end
  end

  // F3: dot product sums
  logic signed [DOTW-1:0] a3_q, e3_q, b3_q, c3_q, f3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q <= DOTW'(paa_q[0]) + DOTW'(paa_q[1]) + DOTW'(paa_q[2]);
      e3_q <= DOTW'(pee_q[0]) + DOTW'(pee_q[1]) + DOTW'(pee_q[2]);
      b3_q <= DOTW'(pbb_q[0]) + DOTW'(pbb_q[1]) + DOTW'(pbb_q[2]);
      c3_q <= DOTW'(pcc_q[0]) + DOTW'(pcc_q[1]) + DOTW'(pcc_q[2]);
      f3_q <= DOTW'(pff_q[0]) + DOTW'(pff_q[1]) + DOTW'(pff_q[2]);
    end
  end

  // F4: degenerate test, case code, operand magnitudes and product signs
  dot_t            dot4_q;
  logic [DOTW-1:0] xm4_q  [NPR];
  logic [DOTW-1:0] ym4_q  [NPR];
  logic            neg4_q [NPR];
  logic            deg1, deg2;
  case_e           cs4;

  always_comb begin
    deg1 = $unsigned(a3_q) <= DOTW'(thr_i);
    deg2 = $unsigned(e3_q) <= DOTW'(thr_i);
    if (deg1 && deg2) begin
      cs4 = CASE_BOTH_DEG;
    end else if (deg1) begin
      cs4 = CASE_FIRST_DEG;
    end else if (deg2) begin
      cs4 = CASE_SECOND_DEG;
    end else begin
      cs4 = CASE_GENERAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot4_q.a  <= a3_q;
      dot4_q.e  <= e3_q;
      dot4_q.b  <= b3_q;
      dot4_q.c  <= c3_q;
      dot4_q.f  <= f3_q;
      dot4_q.cs <= cs4;
      xm4_q[PR_AE]  <= $unsigned(a3_q);
      ym4_q[PR_AE]  <= $unsigned(e3_q);
      neg4_q[PR_AE] <= 1'b0;
      xm4_q[PR_BB]  <= mag(b3_q);
      ym4_q[PR_BB]  <= mag(b3_q);
      neg4_q[PR_BB] <= 1'b0;
      xm4_q[PR_BF]  <= mag(b3_q);
      ym4_q[PR_BF]  <= mag(f3_q);
      neg4_q[PR_BF] <= b3_q[DOTW-1] ^ f3_q[DOTW-1];
      xm4_q[PR_CE]  <= mag(c3_q);
      ym4_q[PR_CE]  <= $unsigned(e3_q);
      neg4_q[PR_CE] <= c3_q[DOTW-1];
    end
  end

  // F5: partial products of the split magnitudes
  dot_t               dot5_q;
  logic               neg5_q [NPR];
  logic [2*HALFW-1:0] hh5_q  [NPR];
  logic [2*HALFW-1:0] hl5_q  [NPR];
  logic [2*HALFW-1:0] lh5_q  [NPR];
  logic [2*HALFW-1:0] ll5_q  [NPR];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot5_q <= dot4_q;
      for (int i = 0; i < NPR; i++) begin
        neg5_q[i] <= neg4_q[i];
        hh5_q[i]  <= xm4_q[i][DOTW-1:HALFW] * ym4_q[i][DOTW-1:HALFW];
        hl5_q[i]  <= xm4_q[i][DOTW-1:HALFW] * ym4_q[i][HALFW-1:0];
        lh5_q[i]  <= xm4_q[i][HALFW-1:0] * ym4_q[i][DOTW-1:HALFW];
        ll5_q[i]  <= xm4_q[i][HALFW-1:0] * ym4_q[i][HALFW-1:0];
      end
    end
  end

  // F6: assemble product magnitudes
  dot_t              dot6_q;
  logic              neg6_q  [NPR];
  logic [2*DOTW-1:0] prod6_q [NPR];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot6_q <= dot5_q;
      for (int i = 0; i < NPR; i++) begin
        neg6_q[i]  <= neg5_q[i];
        prod6_q[i] <= {hh5_q[i], ll5_q[i]}
                      + (((2*DOTW)'(hl5_q[i]) + (2*DOTW)'(lh5_q[i])) << HALFW);
      end
    end
  end

  // F7: signed products, denominator
  dot_t                   dot7_q;
  logic signed [BIGW-1:0] den7_q, bf7_q, ce7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot7_q <= dot6_q;
      den7_q <= $signed({2'b00, prod6_q[PR_AE]}) - $signed({2'b00, prod6_q[PR_BB]});
      bf7_q  <= neg6_q[PR_BF] ? -$signed({2'b00, prod6_q[PR_BF]})
                              :  $signed({2'b00, prod6_q[PR_BF]});
      ce7_q  <= neg6_q[PR_CE] ? -$signed({2'b00, prod6_q[PR_CE]})
                              :  $signed({2'b00, prod6_q[PR_CE]});
    end
  end

  // F8: numerator
  dot_t                   dot8_q;
  logic signed [BIGW-1:0] num8_q, den8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot8_q <= dot7_q;
      num8_q <= bf7_q - ce7_q;
      den8_q <= den7_q;
    end
  end

  // F9: parallel check; a zero denominator makes the quotient zero
  fr_t                    fr_q;
  logic signed [BIGW-1:0] thr_s;
  logic                   not_par;

  always_comb begin
    thr_s   = $signed(BIGW'(thr_i));
    not_par = (den8_q > thr_s) || (den8_q < -thr_s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr_q.dot <= dot8_q;
      fr_q.num <= not_par ? num8_q : '0;
      fr_q.den <= not_par ? den8_q : '0;
    end
  end

  assign fr_o = fr_q;

endmodule

`default_nettype wire

FILE: rtl/core/seg_dist_div.sv
// Pipelined clamped quotient in Q1.16, one quotient bit per stage, rounded.
// Depends on seg_dist_pkg.
`default_nettype none

module seg_dist_div
  import seg_dist_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [BIGW-1:0] num_i,
  input  logic signed [BIGW-1:0] den_i,
  output logic [PF:0]            q_o
);

  logic [BIGW-1:0] rem_q  [PF+1];
  logic [BIGW-1:0] den_q  [PF+1];
  logic [PF-1:0]   quo_q  [PF+1];
  logic            zero_q [PF+1];
  logic            one_q  [PF+1];
  logic [PF:0]     q_q;

  // Entry: clamp checks
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (den_i <= 0) || (num_i <= 0);
      one_q[0]  <= num_i >= den_i;
      rem_q[0]  <= $unsigned(num_i);
      den_q[0]  <= $unsigned(den_i);
      quo_q[0]  <= '0;
    end
  end

  // Restoring steps
  for (genvar k = 1; k <= PF; k++) begin : g_step
    logic [BIGW-1:0] r2;
    logic            ge;

    always_comb begin
      r2 = {rem_q[k-1][BIGW-2:0], 1'b0};
      ge = r2 >= den_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? r2 - den_q[k-1] : r2;
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][PF-2:0], ge};
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
      end
    end
  end

  // Round half up and apply clamps
  logic [BIGW-1:0] rr2;
  logic            rup;

  always_comb begin
    rr2 = {rem_q[PF][BIGW-2:0], 1'b0};
    rup = rr2 >= den_q[PF];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[PF]) begin
        q_q <= '0;
      end else if (one_q[PF]) begin
        q_q <= PAR_ONE;
      end else begin
        q_q <= {1'b0, quo_q[PF]} + (PF+1)'(rup);
      end
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

FILE: rtl/core/seg_dist_sqrt.sv
// Pipelined square root, rounded to nearest, one root bit per stage.
// Depends on seg_dist_pkg.
`default_nettype none

module seg_dist_sqrt
  import seg_dist_pkg::*;
(
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [SQW-1:0] x_i,
  output logic [RTW:0]   root_o
);

  localparam int RMW = RTW + 2;

  logic [SQW-1:0] x_q    [RTW+1];
  logic [RMW-1:0] rem_q  [RTW+1];
  logic [RTW-1:0] root_q [RTW+1];
  logic [RTW:0]   res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  // One root bit per stage from the top two radicand bits
  for (genvar k = 1; k <= RTW; k++) begin : g_step
    logic [RMW-1:0] cur, trial;
    logic           ge;

    always_comb begin
      cur   = {rem_q[k-1][RMW-3:0], x_q[k-1][SQW-1:SQW-2]};
      trial = {root_q[k-1], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_q[k-1][SQW-3:0], 2'b00};
        rem_q[k]  <= ge ? cur - trial : cur;
        root_q[k] <= {root_q[k-1][RTW-2:0], ge};
      end
    end
  end

  // Remainder beyond root means the upper neighbor is nearer
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= {1'b0, root_q[RTW]}
               + (RTW+1)'(rem_q[RTW] > RMW'(root_q[RTW]));
    end
  end

  assign root_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/segment_segment_distance_top.sv
// Top level of the segment-to-segment distance pipeline: register port,
// operand stage, parameter solve, closest points and distance.
// Depends on seg_dist_pkg, seg_dist_front, seg_dist_div and seg_dist_sqrt.
//
//   Port group     Handshake                  Contents
//   input          in_valid_i / in_ready_o    two segments, 12 x Q16.16
//   output         out_valid_o / out_ready_i  distance, s, t, case code
//   register       psel/penable/pwrite        degenerate_threshold at 0x0
//
// One request enters per cycle while in_ready_o is high; the quotient
// pipelines each have 16 restoring steps and the square root pipeline has
// 35 steps.
// Reset clears the valid bits, the output valid and the threshold.
// The pipeline holds only when the output register is full, not taken and a
// result is waiting behind it; all stages then keep their contents.
`default_nettype none

module segment_segment_distance_top
  import seg_dist_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CW-1:0] first_start_x_i,
  input  logic signed [CW-1:0] first_start_y_i,
  input  logic signed [CW-1:0] first_start_z_i,
  input  logic signed [CW-1:0] first_end_x_i,
  input  logic signed [CW-1:0] first_end_y_i,
  input  logic signed [CW-1:0] first_end_z_i,
  input  logic signed [CW-1:0] second_start_x_i,
  input  logic signed [CW-1:0] second_start_y_i,
  input  logic signed [CW-1:0] second_start_z_i,
  input  logic signed [CW-1:0] second_end_x_i,
  input  logic signed [CW-1:0] second_end_y_i,
  input  logic signed [CW-1:0] second_end_z_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DIST_W-1:0]    distance_o,
  output logic [PF:0]          first_param_o,
  output logic [PF:0]          second_param_o,
  output logic [1:0]           case_code_o
);

  localparam logic REG_THR  = 1'b0;
  localparam int   MID_LAT  = 3;
  localparam int   END_LAT  = 5;
  localparam int   GEO_DLY  = FRONT_LAT + 2 * DIV_LAT + MID_LAT;
  localparam int   TOTAL    = 1 + FRONT_LAT + 2 * DIV_LAT + MID_LAT + END_LAT + SQRT_LAT;
  localparam int   PRW      = DW + PF + 2;

  typedef struct packed {
    case_e       cs;
    logic        to_t;
    logic [PF:0] s_fix;
    logic [PF:0] t_fix;
  } side2_t;

  typedef struct packed {
    case_e       cs;
    logic [PF:0] s;
    logic [PF:0] t;
  } res_t;

  // Register port
  logic [31:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THR) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THR)) begin
      thr_q <= pwdata;
    end
  end

  // Global advance and valid bits
  logic             en;
  logic [TOTAL-1:0] vld_q;
  logic             out_valid_q;

  assign en         = !(vld_q[TOTAL-1] && out_valid_q && !out_ready_i);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL-2:0], in_valid_i};
    end
  end

  // S0: endpoint differences
  geo_t geo0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo0_q.p1[0] <= first_start_x_i;
      geo0_q.p1[1] <= first_start_y_i;
      geo0_q.p1[2] <= first_start_z_i;
      geo0_q.p2[0] <= second_start_x_i;
      geo0_q.p2[1] <= second_start_y_i;
      geo0_q.p2[2] <= second_start_z_i;
      geo0_q.d1[0] <= DW'(first_end_x_i) - DW'(first_start_x_i);
      geo0_q.d1[1] <= DW'(first_end_y_i) - DW'(first_start_y_i);
      geo0_q.d1[2] <= DW'(first_end_z_i) - DW'(first_start_z_i);
      geo0_q.d2[0] <= DW'(second_end_x_i) - DW'(second_start_x_i);
      geo0_q.d2[1] <= DW'(second_end_y_i) - DW'(second_start_y_i);
      geo0_q.d2[2] <= DW'(second_end_z_i) - DW'(second_start_z_i);
      geo0_q.rv[0] <= DW'(first_start_x_i) - DW'(second_start_x_i);
      geo0_q.rv[1] <= DW'(first_start_y_i) - DW'(second_start_y_i);
      geo0_q.rv[2] <= DW'(first_start_z_i) - DW'(second_start_z_i);
    end
  end

  // Endpoints wait for the closest point stages
  geo_t geo_dly_q [GEO_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_dly_q[0] <= geo0_q;
      for (int k = 1; k < GEO_DLY; k++) begin
        geo_dly_q[k] <= geo_dly_q[k-1];
      end
    end
  end

  // Front end and first quotient
  fr_t         fr;
  logic [PF:0] q1;
  dot_t        dot1_q [DIV_LAT];

  seg_dist_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .thr_i (thr_q),
    .geo_i (geo0_q),
    .fr_o  (fr)
  );

  seg_dist_div u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (fr.num),
    .den_i (fr.den),
    .q_o   (q1)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot1_q[0] <= fr.dot;
      for (int k = 1; k < DIV_LAT; k++) begin
        dot1_q[k] <= dot1_q[k-1];
      end
    end
  end

  // M1: b*s0
  dot_t                 dot_m1_q;
  logic [PF:0]          s0_m1_q;
  logic signed [NW-1:0] prod_m1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_m1_q  <= dot1_q[DIV_LAT-1];
      s0_m1_q   <= q1;
      prod_m1_q <= dot1_q[DIV_LAT-1].b * $signed({1'b0, q1});
    end
  end

  // M2: n = b*s0 + f*2^16
  dot_t                 dot_m2_q;
  logic [PF:0]          s0_m2_q;
  logic signed [NW-1:0] n_m2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_m2_q <= dot_m1_q;
      s0_m2_q  <= s0_m1_q;
      n_m2_q   <= prod_m1_q + (NW'(dot_m1_q.f) <<< PF);
    end
  end

  // M3: choose the second quotient and which parameter it feeds
  logic signed [NW-1:0]   eh;
  logic signed [BIGW-1:0] num2_d, den2_d, num2_q, den2_q;
  side2_t                 side2_d, side2_q;
  side2_t                 side2_dly_q [DIV_LAT];

  always_comb begin
    eh            = NW'(dot_m2_q.e) <<< PF;
    side2_d.cs    = dot_m2_q.cs;
    side2_d.to_t  = 1'b0;
    side2_d.s_fix = '0;
    side2_d.t_fix = '0;
    num2_d        = '0;
    den2_d        = '0;
    case (dot_m2_q.cs)
      CASE_BOTH_DEG: begin
        num2_d = '0;
      end
      CASE_FIRST_DEG: begin
        side2_d.to_t = 1'b1;
        num2_d       = BIGW'(dot_m2_q.f);
        den2_d       = BIGW'(dot_m2_q.e);
      end
      CASE_SECOND_DEG: begin
        num2_d = -BIGW'(dot_m2_q.c);
        den2_d = BIGW'(dot_m2_q.a);
      end
      CASE_GENERAL: begin
        if (n_m2_q < 0) begin
          num2_d = -BIGW'(dot_m2_q.c);
          den2_d = BIGW'(dot_m2_q.a);
        end else if (n_m2_q > eh) begin
          side2_d.t_fix = PAR_ONE;
          num2_d        = BIGW'(dot_m2_q.b) - BIGW'(dot_m2_q.c);
          den2_d        = BIGW'(dot_m2_q.a);
        end else begin
          side2_d.to_t  = 1'b1;
          side2_d.s_fix = s0_m2_q;
          num2_d        = BIGW'(n_m2_q);
          den2_d        = BIGW'(eh);
        end
      end
      default: begin
        num2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_q  <= num2_d;
      den2_q  <= den2_d;
      side2_q <= side2_d;
    end
  end

  // Second quotient
  logic [PF:0] q2;

  seg_dist_div u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num2_q),
    .den_i (den2_q),
    .q_o   (q2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_dly_q[0] <= side2_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        side2_dly_q[k] <= side2_dly_q[k-1];
      end
    end
  end

  // E1: final s, t and the scaled direction products
  side2_t                side2_e;
  geo_t                  geo_e;
  res_t                  res_e1_d, res_e1_q;
  logic [2:0][CW-1:0]    p1_e1_q, p2_e1_q;
  logic signed [PRW-1:0] pr1_e1_q [3];
  logic signed [PRW-1:0] pr2_e1_q [3];

  always_comb begin
    side2_e     = side2_dly_q[DIV_LAT-1];
    geo_e       = geo_dly_q[GEO_DLY-1];
    res_e1_d.cs = side2_e.cs;
    res_e1_d.s  = side2_e.to_t ? side2_e.s_fix : q2;
    res_e1_d.t  = side2_e.to_t ? q2 : side2_e.t_fix;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_e1_q <= res_e1_d;
      p1_e1_q  <= geo_e.p1;
      p2_e1_q  <= geo_e.p2;
      for (int i = 0; i < 3; i++) begin
        pr1_e1_q[i] <= $signed(geo_e.d1[i]) * $signed({1'b0, res_e1_d.s});
        pr2_e1_q[i] <= $signed(geo_e.d2[i]) * $signed({1'b0, res_e1_d.t});
      end
    end
  end

  // E2: closest points, products rounded half up
  res_t                  res_e2_q;
  logic signed [PRW-1:0] rs1 [3];
  logic signed [PRW-1:0] rs2 [3];
  logic signed [CPW-1:0] c1_e2_q [3];
  logic signed [CPW-1:0] c2_e2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs1[i] = pr1_e1_q[i] + (PRW'(1) << (PF - 1));
      rs1[i] = rs1[i] >>> PF;
      rs2[i] = pr2_e1_q[i] + (PRW'(1) << (PF - 1));
      rs2[i] = rs2[i] >>> PF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_e2_q <= res_e1_q;
      for (int i = 0; i < 3; i++) begin
        c1_e2_q[i] <= CPW'($signed(p1_e1_q[i])) + CPW'(rs1[i]);
        c2_e2_q[i] <= CPW'($signed(p2_e1_q[i])) + CPW'(rs2[i]);
      end
    end
  end

  // E3: component distance magnitudes
  res_t                  res_e3_q;
  logic signed [CPW:0]   df [3];
  logic [MAGW-1:0]       mag_e3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i] = (CPW+1)'(c1_e2_q[i]) - (CPW+1)'(c2_e2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_e3_q <= res_e2_q;
      for (int i = 0; i < 3; i++) begin
        mag_e3_q[i] <= df[i][CPW] ? MAGW'(-df[i]) : MAGW'(df[i]);
      end
    end
  end

  // E4: split squares
  res_t            res_e4_q;
  logic [2*MH-1:0] hh_e4_q [3];
  logic [2*MH-1:0] hl_e4_q [3];
  logic [2*MH-1:0] ll_e4_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_e4_q <= res_e3_q;
      for (int i = 0; i < 3; i++) begin
        hh_e4_q[i] <= mag_e3_q[i][MAGW-1:MH] * mag_e3_q[i][MAGW-1:MH];
        hl_e4_q[i] <= mag_e3_q[i][MAGW-1:MH] * mag_e3_q[i][MH-1:0];
        ll_e4_q[i] <= mag_e3_q[i][MH-1:0] * mag_e3_q[i][MH-1:0];
      end
    end
  end

  // E5: sum of squares
  res_t           res_e5_q;
  logic [SQW-1:0] sq [3];
  logic [SQW-1:0] sum_e5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = SQW'({hh_e4_q[i], ll_e4_q[i]}) + (SQW'(hl_e4_q[i]) << (MH + 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_e5_q <= res_e4_q;
      sum_e5_q <= sq[0] + sq[1] + sq[2];
    end
  end

  // Square root, parameters wait alongside
  logic [RTW:0] root;
  res_t         res_dly_q [SQRT_LAT];

  seg_dist_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (sum_e5_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_dly_q[0] <= res_e5_q;
      for (int k = 1; k < SQRT_LAT; k++) begin
        res_dly_q[k] <= res_dly_q[k-1];
      end
    end
  end

  // Output register
  logic [DIST_W-1:0] dist_q;
  res_t              res_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && !out_ready_i)) begin
      out_valid_q <= vld_q[TOTAL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!(out_valid_q && !out_ready_i)) begin
      dist_q    <= (root > (RTW+1)'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
      res_out_q <= res_dly_q[SQRT_LAT-1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign distance_o     = dist_q;
  assign first_param_o  = res_out_q.s;
  assign second_param_o = res_out_q.t;
  assign case_code_o    = res_out_q.cs;

endmodule

`default_nettype wire
